/* rtl/can_bit_timing_search_assert.svh */
// Assertion macros shared by the bit timing search RTL.
// Both forms sample on clk and stay quiet while rst_n is low.
`ifndef CAN_BIT_TIMING_SEARCH_ASSERT_SVH
`define CAN_BIT_TIMING_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define CBTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cbts_pkg.sv */
package cbts_pkg;

  // Field widths of the input item
  localparam int CLK_W   = 31;
  localparam int RATE_W  = 24;
  localparam int PCT_W   = 7;
  localparam int PLIM_W  = 10;
  localparam int S1LIM_W = 9;
  localparam int S2LIM_W = 8;

  // Field widths of the result item
  localparam int PRESC_W = 10;
  localparam int SEG1_W  = 9;
  localparam int SEG2_W  = 8;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 32;

  // Search limit defaults
  localparam int DEF_MAX_PRESCALER = 512;
  localparam int DEF_MAX_SEG1      = 256;
  localparam int DEF_MAX_SEG2      = 128;

  localparam int PERCENT_SCALE = 100;

  // Divider handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [31:0] lim_clamp(input logic [31:0] v, input logic [31:0] cap);
    lim_clamp = (v < cap) ? v : cap;
  endfunction

endpackage

/* rtl/cbts_div.sv */
`include "can_bit_timing_search_assert.svh"

// Restoring divider, one quotient bit per cycle.
module cbts_div import cbts_pkg::*; #(
  parameter int DVSR_W = RATE_W + 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CLK_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic [CLK_W-1:0]  quotient,
  output logic [CLK_W-1:0]  remainder,
  output div_stat_t         stat
);

  localparam int CNT_W = $clog2(CLK_W + 1);
  localparam int CMP_W = (CLK_W > DVSR_W) ? CLK_W : DVSR_W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CLK_W-1:0]  quo_r, quo_nxt;
  logic [CLK_W-1:0]  rem_r, rem_nxt;
  logic [DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [CLK_W-1:0]  partial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder
  assign partial = {rem_r[CLK_W-2:0], quo_r[CLK_W-1]};
  assign fits    = CMP_W'(partial) >= CMP_W'(dvsr_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(CLK_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? (partial - CLK_W'(dvsr_r)) : partial;
      quo_nxt = {quo_r[CLK_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign quotient    = quo_r;
  assign remainder   = rem_r;
  assign stat.busy   = busy_r;
  assign stat.done   = done_r;

  `CBTS_ASSERT_IMP(a_start_idle, start, !busy_r, "divider started while busy")
  `CBTS_ASSERT_NXT(a_done_pulse, done_r, !done_r, "divider done held over two cycles")
  `CBTS_ASSERT_NXT(a_last_step, busy_r && (cnt_r == CNT_W'(1)), done_r, "divider done missing")

endmodule

/* rtl/can_bit_timing_search.sv */
// Channel  Dir  Width  Contents
// in_*     in   96     one timing request (clock, rate, sample point, limits)
// out_*    out  32+1   chosen prescaler and segments, found flag in tuser
//
// One request at a time; in_tready is high only in idle, between searches.
// Each prescaler goes through multiply, divider start, serial division and
// result, step; an exact one adds a check and a divide per phase-2 candidate.
// Reset is synchronous, rst_n low. A result waits in the output register; a
// second finished search holds until that register frees, stalling in_*.
`include "can_bit_timing_search_assert.svh"

module can_bit_timing_search import cbts_pkg::*; #(
  parameter int MAX_PRESCALER = DEF_MAX_PRESCALER,
  parameter int MAX_SEG1      = DEF_MAX_SEG1,
  parameter int MAX_SEG2      = DEF_MAX_SEG2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // clock_hz[30:0], bit_rate[54:31], sample_percent[61:55],
  // prescaler_limit[71:62], seg1_limit[80:72], seg2_limit[88:81], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // prescaler[9:0], seg1[18:10], seg2[26:19], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // found[0]
  output logic                   out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready
);

  localparam int PW     = $clog2(MAX_PRESCALER + 1);
  localparam int S1W    = $clog2(MAX_SEG1 + 1);
  localparam int S2W    = $clog2(MAX_SEG2 + 2);
  localparam int DVSR_W = RATE_W + PW;
  localparam int NUM_W  = $clog2(PERCENT_SCALE * (MAX_SEG1 + 1) + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_MUL      = 9'b000000010,
    S_TOT_GO   = 9'b000000100,
    S_TOT_WAIT = 9'b000001000,
    S_CAND     = 9'b000010000,
    S_SP_GO    = 9'b000100000,
    S_SP_WAIT  = 9'b001000000,
    S_NEXTP    = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Request, held for the whole search
  logic [CLK_W-1:0]  clk_hz_r, clk_hz_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [PCT_W-1:0]  want_r, want_nxt;
  logic [S1W-1:0]    s1lim_r, s1lim_nxt;
  logic [S2W-1:0]    s2lim_r, s2lim_nxt;

  // Search counters and working values
  logic [PW-1:0]     p_r, p_nxt;
  logic [S2W-1:0]    s2_r, s2_nxt;
  logic [DVSR_W-1:0] prod_r, prod_nxt;
  logic [CLK_W-1:0]  total_r, total_nxt;
  logic [S1W-1:0]    s1c_r, s1c_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;

  // Best candidate so far
  logic              found_r, found_nxt;
  logic [PCT_W-1:0]  err_r, err_nxt;
  logic [PW-1:0]     best_p_r, best_p_nxt;
  logic [S1W-1:0]    best_s1_r, best_s1_nxt;
  logic [S2W-1:0]    best_s2_r, best_s2_nxt;

  // Output register
  logic                   out_vld_r, out_vld_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_free;

  // Shared divider
  logic              div_start;
  logic              div_wait;
  logic [CLK_W-1:0]  div_dvd;
  logic [DVSR_W-1:0] div_dvsr;
  logic [CLK_W-1:0]  div_quo;
  logic [CLK_W-1:0]  div_rem;
  div_stat_t         div_stat;

  // Request unpack and limit clamping
  logic [PW-1:0]     in_plim;
  logic [RATE_W-1:0] in_rate;

  // Candidate arithmetic
  logic [CLK_W:0]    tot_ext;
  logic [CLK_W:0]    need;
  logic [CLK_W-1:0]  s1_w;
  logic [PCT_W-1:0]  sp;
  logic [PCT_W-1:0]  err;

  assign in_rate = in_tdata[54:31];
  assign in_plim = PW'(lim_clamp(32'(in_tdata[71:62]), 32'(MAX_PRESCALER)));

  // seg1 = total - seg2 - 1 is usable only when total >= seg2 + 2
  assign tot_ext = {1'b0, total_r};
  assign need    = (CLK_W + 1)'(s2_r) + (CLK_W + 1)'(2);
  assign s1_w    = total_r - CLK_W'(s2_r) - CLK_W'(1);

  // Sample point is below 100 here, so the low quotient bits carry it
  assign sp  = PCT_W'(div_quo);
  assign err = (sp > want_r) ? (sp - want_r) : (want_r - sp);

  // Operands only matter in the cycle that starts the divider
  assign div_start = (state_r == S_TOT_GO) || (state_r == S_SP_GO);
  assign div_wait  = (state_r == S_TOT_WAIT) || (state_r == S_SP_WAIT);
  assign div_dvd   = (state_r == S_SP_GO) ? CLK_W'(num_r) : clk_hz_r;
  assign div_dvsr  = (state_r == S_SP_GO) ? DVSR_W'(total_r) : prod_r;

  // The output register takes a new result when empty or drained this cycle
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    clk_hz_nxt    = clk_hz_r;
    rate_nxt      = rate_r;
    want_nxt      = want_r;
    s1lim_nxt     = s1lim_r;
    s2lim_nxt     = s2lim_r;
    p_nxt         = p_r;
    s2_nxt        = s2_r;
    prod_nxt      = prod_r;
    total_nxt     = total_r;
    s1c_nxt       = s1c_r;
    num_nxt       = num_r;
    found_nxt     = found_r;
    err_nxt       = err_r;
    best_p_nxt    = best_p_r;
    best_s1_nxt   = best_s1_r;
    best_s2_nxt   = best_s2_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_found_nxt = out_found_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          // Take the request and clear the best candidate
          clk_hz_nxt  = in_tdata[30:0];
          rate_nxt    = in_rate;
          want_nxt    = in_tdata[61:55];
          s1lim_nxt   = S1W'(lim_clamp(32'(in_tdata[80:72]), 32'(MAX_SEG1)));
          s2lim_nxt   = S2W'(lim_clamp(32'(in_tdata[88:81]), 32'(MAX_SEG2)));
          p_nxt       = in_plim;
          found_nxt   = 1'b0;
          err_nxt     = '0;
          best_p_nxt  = '0;
          best_s1_nxt = '0;
          best_s2_nxt = '0;
          if ((in_rate == '0) || (in_plim == '0)) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = DVSR_W'(rate_r * p_r);
        state_nxt = S_TOT_GO;
      end
      S_TOT_GO: begin
        state_nxt = S_TOT_WAIT;
      end
      S_TOT_WAIT: begin
        if (div_stat.done) begin
          // Use only prescalers that divide the clock exactly
          if (div_rem == '0) begin
            total_nxt = div_quo;
            s2_nxt    = S2W'(1);
            state_nxt = S_CAND;
          end else begin
            state_nxt = S_NEXTP;
          end
        end
      end
      S_CAND: begin
        // Past the seg2 limit, or when every larger seg2 also leaves seg1 below one: drop the prescaler
        if ((s2_r > s2lim_r) || (tot_ext < need)) begin
          state_nxt = S_NEXTP;
        end else if (s1_w > CLK_W'(s1lim_r)) begin
          s2_nxt = s2_r + S2W'(1);
        end else begin
          s1c_nxt   = S1W'(s1_w);
          num_nxt   = NUM_W'(32'(PERCENT_SCALE) * (32'(s1_w[S1W-1:0]) + 32'd1));
          state_nxt = S_SP_GO;
        end
      end
      S_SP_GO: begin
        state_nxt = S_SP_WAIT;
      end
      S_SP_WAIT: begin
        if (div_stat.done) begin
          // Ties go to the later candidate
          if (!found_r || (err <= err_r)) begin
            found_nxt   = 1'b1;
            err_nxt     = err;
            best_p_nxt  = p_r;
            best_s1_nxt = s1c_r;
            best_s2_nxt = s2_r;
          end
          s2_nxt    = s2_r + S2W'(1);
          state_nxt = S_CAND;
        end
      end
      S_NEXTP: begin
        if (p_r == PW'(1)) begin
          state_nxt = S_OUT;
        end else begin
          p_nxt     = p_r - PW'(1);
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        // Hold the finished search until the output register frees
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_found_nxt = found_r;
          // Best fields stay zero when nothing was found
          out_data_nxt  = {
            {(OUT_TDATA_W - PRESC_W - SEG1_W - SEG2_W){1'b0}},
            SEG2_W'(best_s2_r),
            SEG1_W'(best_s1_r),
            PRESC_W'(best_p_r)
          };
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
    clk_hz_r    <= clk_hz_nxt;
    rate_r      <= rate_nxt;
    want_r      <= want_nxt;
    s1lim_r     <= s1lim_nxt;
    s2lim_r     <= s2lim_nxt;
    p_r         <= p_nxt;
    s2_r        <= s2_nxt;
    prod_r      <= prod_nxt;
    total_r     <= total_nxt;
    s1c_r       <= s1c_nxt;
    num_r       <= num_nxt;
    found_r     <= found_nxt;
    err_r       <= err_nxt;
    best_p_r    <= best_p_nxt;
    best_s1_r   <= best_s1_nxt;
    best_s2_r   <= best_s2_nxt;
    out_found_r <= out_found_nxt;
    out_data_r  <= out_data_nxt;
  end

  cbts_div #(
    .DVSR_W (DVSR_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvsr),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_data_r;

  `CBTS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "stalled result dropped")
  `CBTS_ASSERT_IMP(a_nf_zero, out_tvalid && !out_tuser, out_tdata == '0, "not found with data")
  `CBTS_ASSERT_IMP(a_done_wait, div_stat.done, div_wait, "divider result unclaimed")
  `CBTS_ASSERT_IMP(a_go_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `CBTS_ASSERT_IMP(a_p_live, state_r == S_MUL, p_r != '0, "zero prescaler searched")

endmodule

/* test/tb_can_bit_timing_search.sv */
`timescale 1ns / 100ps

module tb_can_bit_timing_search;
  import cbts_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 8;
  // The slowest request generated here, even behind a long output hold, stays
  // well under this limit.
  localparam int WATCHDOG_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES    = 200;
  localparam int LONG_HOLD_CYCLES = 5000;

  localparam logic [CLK_W-1:0]  CLK_HZ_MAX = '1;
  localparam logic [RATE_W-1:0] RATE_MAX   = '1;

  // One timing request; packed so that clock_hz lands in the lowest bits,
  // matching the in_tdata layout.
  typedef struct packed {
    logic [S2LIM_W-1:0] seg2_limit;
    logic [S1LIM_W-1:0] seg1_limit;
    logic [PLIM_W-1:0]  prescaler_limit;
    logic [PCT_W-1:0]   sample_percent;
    logic [RATE_W-1:0]  bit_rate;
    logic [CLK_W-1:0]   clock_hz;
  } timing_req_t;

  typedef struct packed {
    logic               found;
    logic [PRESC_W-1:0] prescaler;
    logic [SEG1_W-1:0]  seg1;
    logic [SEG2_W-1:0]  seg2;
  } bit_timing_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  // clock_hz, bit_rate, sample_percent, prescaler_limit, seg1_limit,
  // seg2_limit, zero pad (lowest bit up)
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // prescaler, seg1, seg2, zero pad (lowest bit up)
  logic [OUT_TDATA_W-1:0] out_tdata;
  // found
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  bit_timing_t pending_timings[$];
  int          mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int          hold_requests  = 0;
  int          holds_served   = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;

  can_bit_timing_search u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Predict the chosen timing: walk prescalers downward, keep every exact
  // divisor, walk phase-2 upward and keep the in-range candidate whose
  // sample point is closest; an equal error replaces the earlier pick.
  function automatic bit_timing_t search_bit_timing(input timing_req_t req);
    longint unsigned clk_hz, rate, want_pct, plim, s1lim, s2lim;
    longint unsigned presc, s2, quanta, s1, sp, err, best_err;
    bit_timing_t     best;
    best     = '0;
    best_err = '1;
    clk_hz   = req.clock_hz;
    rate     = req.bit_rate;
    want_pct = req.sample_percent;
    plim     = (req.prescaler_limit < DEF_MAX_PRESCALER) ? req.prescaler_limit
                                                         : DEF_MAX_PRESCALER;
    s1lim    = (req.seg1_limit < DEF_MAX_SEG1) ? req.seg1_limit : DEF_MAX_SEG1;
    s2lim    = (req.seg2_limit < DEF_MAX_SEG2) ? req.seg2_limit : DEF_MAX_SEG2;
    if (rate != 0) begin
      for (presc = plim; presc >= 1; presc--) begin
        if (clk_hz % (rate * presc) == 0) begin
          quanta = clk_hz / (rate * presc);
          for (s2 = 1; s2 <= s2lim; s2++) begin
            if (quanta >= s2 + 2) begin
              s1 = quanta - s2 - 1;
              if (s1 <= s1lim) begin
                sp  = (PERCENT_SCALE * (1 + s1)) / quanta;
                err = (sp > want_pct) ? sp - want_pct : want_pct - sp;
                if (err <= best_err) begin
                  best_err       = err;
                  best.found     = 1'b1;
                  best.prescaler = PRESC_W'(presc);
                  best.seg1      = SEG1_W'(s1);
                  best.seg2      = SEG2_W'(s2);
                end
              end
            end
          end
        end
      end
    end
    return best;
  endfunction

  function automatic timing_req_t make_req(input longint unsigned clk_hz,
                                           input longint unsigned rate,
                                           input int unsigned pct,
                                           input int unsigned plim,
                                           input int unsigned s1lim,
                                           input int unsigned s2lim);
    timing_req_t req;
    req.clock_hz        = CLK_W'(clk_hz);
    req.bit_rate        = RATE_W'(rate);
    req.sample_percent  = PCT_W'(pct);
    req.prescaler_limit = PLIM_W'(plim);
    req.seg1_limit      = S1LIM_W'(s1lim);
    req.seg2_limit      = S2LIM_W'(s2lim);
    return req;
  endfunction

  // Mostly build the clock from rate * prescaler * quanta so that exact
  // divisors exist and the segment search actually runs; the rest is noise.
  // Keep search ranges small except for a few wide ones.
  function automatic timing_req_t random_request();
    timing_req_t     req;
    longint unsigned presc, quanta, rate, scale;
    int unsigned     pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      req.clock_hz       = CLK_W'($urandom);
      req.bit_rate       = RATE_W'($urandom);
      req.sample_percent = PCT_W'($urandom);
    end else begin
      presc  = $urandom_range(16, 1);
      quanta = $urandom_range(25, 3);
      scale  = $urandom_range(4, 1);
      case ($urandom_range(2))
        0:       rate = $urandom_range(1_000_000, 10_000);
        1:       rate = $urandom_range(1000, 1);
        default: rate = 125_000 << $urandom_range(3);
      endcase
      req.clock_hz       = CLK_W'(rate * presc * quanta * scale);
      req.bit_rate       = RATE_W'(rate);
      req.sample_percent = ($urandom_range(9) == 0) ? PCT_W'($urandom)
                                                    : PCT_W'($urandom_range(95, 50));
    end
    req.prescaler_limit = PLIM_W'($urandom_range(32, 0));
    req.seg1_limit      = S1LIM_W'($urandom_range(40, 0));
    req.seg2_limit      = S2LIM_W'($urandom_range(24, 0));
    pick = $urandom_range(11);
    if (pick == 0) begin
      req.prescaler_limit = PLIM_W'($urandom);
      req.seg2_limit      = S2LIM_W'($urandom_range(16, 0));
    end else if (pick == 1) begin
      req.seg1_limit = S1LIM_W'($urandom);
      req.seg2_limit = S2LIM_W'($urandom);
    end
    return req;
  endfunction

  // Offer one request, with a random gap first; valid stays high afterward
  // so that back-to-back requests need no extra assignment.
  task automatic offer_request(input timing_req_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(req);
    do @(posedge clk); while (!in_tready);
    pending_timings.push_back(search_bit_timing(req));
  endtask

  // Drop valid and hold off until every expected timing has come back.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_timings.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    send_idle_pct = 16;
    recv_idle_pct = 65;
    // exact limits, several exact prescalers
    offer_request(make_req(40_000_000, 1_000_000, 75, 512, 256, 128));
    // zero bit rate: no search
    offer_request(make_req(80_000_000, 0, 87, 16, 16, 8));
    // zero clock: every prescaler divides, but no quanta
    offer_request(make_req(0, 500_000, 87, 4, 16, 4));
    // a single quantum per bit
    offer_request(make_req(1, 1, 0, 1, 1, 1));
    // all-ones fields: limits saturate, nothing divides the prime clock
    offer_request(make_req(CLK_HZ_MAX, RATE_MAX, 127, 1023, 511, 255));
    // huge quanta count, phase-1 out of range
    offer_request(make_req(CLK_HZ_MAX, 1, 50, 1, 16, 16));
    // zero limits, all together and one at a time
    offer_request(make_req(8_000_000, 1_000_000, 75, 0, 0, 0));
    offer_request(make_req(8_000_000, 1_000_000, 75, 0, 16, 8));
    offer_request(make_req(8_000_000, 1_000_000, 75, 1, 0, 8));
    offer_request(make_req(8_000_000, 1_000_000, 75, 1, 16, 0));
    // equal error inside one prescaler: the larger phase-2 wins
    offer_request(make_req(8_000_000, 1_000_000, 81, 1, 16, 8));
    // equal error across prescalers: the smaller prescaler wins
    offer_request(make_req(24_000_000, 1_000_000, 75, 3, 32, 16));
    // sample point extremes
    offer_request(make_req(16_000_000, 1_000_000, 0, 4, 64, 32));
    offer_request(make_req(16_000_000, 1_000_000, 100, 4, 64, 32));
    offer_request(make_req(16_000_000, 1_000_000, 127, 4, 64, 32));
    // phase-1 right at its limit, then just beyond
    offer_request(make_req(8_000_000, 1_000_000, 87, 1, 6, 8));
    offer_request(make_req(8_000_000, 1_000_000, 87, 1, 5, 8));
    // only the first phase-2 value allowed
    offer_request(make_req(8_000_000, 1_000_000, 87, 1, 16, 1));
    // top bit of the rate, five quanta per bit
    offer_request(make_req(80_000_000, 16_000_000, 80, 8, 8, 8));
    // smallest usable bit: three quanta
    offer_request(make_req(3_000_000, 1_000_000, 66, 1, 4, 4));
    // no prescaler divides the clock
    offer_request(make_req(10_000_000, 3_000_000, 75, 8, 16, 8));
    // a typical setting
    offer_request(make_req(48_000_000, 250_000, 87, 64, 16, 8));
  endtask

  task automatic test_random_traffic(input int count, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) offer_request(random_request());
  endtask

  // Stall the result side for a long stretch while requests keep coming, so
  // the finished results back up and in_tready stays low.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    offer_request(make_req(16_000_000, 1_000_000, 87, 4, 16, 8));
    offer_request(make_req(24_000_000, 500_000, 75, 6, 32, 8));
    offer_request(make_req(12_000_000, 1_000_000, 66, 3, 8, 4));
    offer_request(random_request());
    wait_for_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    wait_for_drain();
    test_random_traffic(25, 16, 65);
    test_output_backpressure();
    test_random_traffic(25, 65, 16);
    wait_for_drain();
    test_random_traffic(25, 0, 0);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_timings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side ready: a requested long hold takes precedence over random
  // stalls.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result transfer against the oldest prediction.
  always @(posedge clk) begin
    bit_timing_t got;
    bit_timing_t exp_timing;
    if (rst_n && out_tvalid && out_tready) begin
      got.found     = out_tuser;
      got.prescaler = out_tdata[PRESC_W-1:0];
      got.seg1      = out_tdata[PRESC_W +: SEG1_W];
      got.seg2      = out_tdata[PRESC_W + SEG1_W +: SEG2_W];
      if (pending_timings.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        $display("%0t: unexpected result, expected none, ", $time,
                 "got found=%0d presc=%0d seg1=%0d seg2=%0d",
                 got.found, got.prescaler, got.seg1, got.seg2);
      end else begin
        exp_timing = pending_timings.pop_front();
        if (got.found !== exp_timing.found || got.prescaler !== exp_timing.prescaler ||
            got.seg1 !== exp_timing.seg1 || got.seg2 !== exp_timing.seg2) begin
          mismatch_count <= mismatch_count + 1;
          $display("%0t: mismatch, expected found=%0d presc=%0d seg1=%0d seg2=%0d, ",
                   $time, exp_timing.found, exp_timing.prescaler, exp_timing.seg1,
                   exp_timing.seg2,
                   "got found=%0d presc=%0d seg1=%0d seg2=%0d",
                   got.found, got.prescaler, got.seg1, got.seg2);
        end
      end
    end
  end

  // End the run when no transfer has happened for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
